// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the saturator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is low
`define AWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also holds through reset
`define AWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/awsat_pkg.sv -----
// ----------------------------------------------------------------------------
// awsat_pkg
// Shared types, constants and fixed-point helpers of the waveshaping saturator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awsat_pkg;

  localparam int WW         = 32;   // intermediate sample-domain width
  localparam int CW         = 32;   // coefficient width
  localparam int XW         = 80;   // scratch width for rounding and clipping
  localparam int FR_W       = 17;   // wet and volume register width
  localparam int UNITY      = 65536;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_NW     = 63;   // dividend magnitude bits
  localparam int DIV_DW     = 33;   // divisor magnitude bits
  localparam int Q_DEPTH    = 4;

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [XW-1:0] ext_t;

  typedef enum logic [1:0] {
    CURVE_KNEE     = 2'd0,
    CURVE_RATIONAL = 2'd1,
    CURVE_QUAD     = 2'd2,
    CURVE_LINEAR   = 2'd3
  } curve_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CURVE  = 3'd0,
    REG_COEF0  = 3'd1,
    REG_COEF1  = 3'd2,
    REG_COEF2  = 3'd3,
    REG_COEF3  = 3'd4,
    REG_COEF4  = 3'd5,
    REG_WET    = 3'd6,
    REG_VOLUME = 3'd7
  } reg_idx_t;

  typedef struct packed {
    curve_t          curve;
    coef_t           c0;
    coef_t           c1;
    coef_t           c2;
    coef_t           c3;
    coef_t           c4;
    logic [FR_W-1:0] wet;
    logic [FR_W-1:0] vol;
  } cfg_t;

  typedef struct packed {
    logic not_empty;
    logic nearly_full;
  } q_status_t;

  localparam ext_t WIDE_MAX = ext_t'(64'sd2147483647);
  localparam ext_t WIDE_MIN = ext_t'(-64'sd2147483648);

  // clip to the signed 32-bit range
  function automatic wide_t sat_w(ext_t v);
    wide_t r;
    if (v > WIDE_MAX) r = wide_t'(WIDE_MAX);
    else if (v < WIDE_MIN) r = wide_t'(WIDE_MIN);
    else r = wide_t'(v);
    return r;
  endfunction

  // rounding right shift, ties toward plus infinity, n of at least one
  function automatic ext_t rshr(ext_t v, int unsigned n);
    ext_t half;
    half = ext_t'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

endpackage

// ----- hdl/awsat_front.sv -----
// ----------------------------------------------------------------------------
// awsat_front
// Takes samples in, applies the input drive and prepares the rational divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awsat_front #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 16,
  parameter int IW             = 24 + 32 + 33 + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          channel,
  input  logic                          last,
  input  awsat_pkg::cfg_t               cfg,
  input  awsat_pkg::q_status_t          qs,
  output logic                          push,
  output logic [IW-1:0]                 item
);
  import awsat_pkg::*;

  localparam int SFRAC = SAMPLE_BITS - 1;

  logic                          v1_r, v1_nxt;
  logic signed [SAMPLE_BITS-1:0] x1_r;
  logic                          ch1_r, last1_r;
  logic                          accept;

  logic signed [SAMPLE_BITS:0]      ax;
  logic signed [SAMPLE_BITS+CW-1:0] ps;
  logic signed [SAMPLE_BITS+CW:0]   pc;
  ext_t                             cax_e;
  wide_t                            s_c;
  logic signed [CW:0]               cax_c;

  // input handshake
  assign busy   = qs.nearly_full;
  assign accept = start && !busy;
  assign v1_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r    <= sample;
      ch1_r   <= channel;
      last1_r <= last;
    end
  end

  // drive and scaled magnitude for the rational divisor
  always_comb begin
    ax    = (x1_r < 0) ? -((SAMPLE_BITS+1)'(x1_r)) : (SAMPLE_BITS+1)'(x1_r);
    ps    = x1_r * cfg.c0;
    pc    = ax * cfg.c0;
    s_c   = sat_w(rshr(ext_t'(ps), COEF_FRAC_BITS));
    cax_e = rshr(ext_t'(pc), SFRAC);
    cax_c = cax_e[CW:0];
  end

  assign push = v1_r;
  assign item = {x1_r, s_c, cax_c, ch1_r, last1_r};

endmodule

// ----- hdl/awsat_queue.sv -----
// ----------------------------------------------------------------------------
// awsat_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module awsat_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [WIDTH-1:0]            wdata,
  output logic [WIDTH-1:0]            rdata,
  output awsat_pkg::q_status_t        status
);
  import awsat_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  // the back part takes an entry every cycle one is there
  assign pop = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata              = mem_r[rd_ptr_r];
  assign status.not_empty   = pop;
  assign status.nearly_full = (count_r >= CNT_W'(DEPTH - 1));

  `AWS_ASSERT(a_q_no_overflow, !(push && !pop && count_r == CNT_W'(DEPTH)), "queue overflow")
  `AWS_ASSERT(a_q_count_track, count_r == $past(count_r) + CNT_W'($past(push)) - CNT_W'($past(pop)), "queue count slip")

endmodule

// ----- hdl/awsat_div.sv -----
// ----------------------------------------------------------------------------
// awsat_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module awsat_div #(
  parameter int NW = 63,
  parameter int DW = 33,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW+1];
  logic [DW-1:0] rem_r  [NW+1];
  logic [NW-1:0] nq_r   [NW+1];
  logic [DW-1:0] den_r  [NW+1];
  logic [SW-1:0] side_r [NW+1];

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    nq_r[0]   <= in_num;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
  end

  // one trial subtraction per stage
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   sh;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] nq_nxt;

    always_comb begin
      sh      = {rem_r[k], nq_r[k][NW-1]};
      ge      = (sh >= {1'b0, den_r[k]});
      rem_nxt = ge ? DW'(sh - {1'b0, den_r[k]}) : sh[DW-1:0];
      nq_nxt  = {nq_r[k][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= rem_nxt;
      nq_r[k+1]   <= nq_nxt;
      den_r[k+1]  <= den_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = vld_r[NW];
  assign out_quot  = nq_r[NW];
  assign out_side  = side_r[NW];

  `AWS_ASSERT(a_div_latency, vld_r[0] |-> ##(NW) vld_r[NW], "divider lost a transaction")

endmodule

// ----- hdl/awsat_back.sv -----
// ----------------------------------------------------------------------------
// awsat_back
// Curve evaluation, quotient, wet/dry mix, master gain and output clipping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awsat_back #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 16,
  parameter int IW             = 24 + 32 + 33 + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  awsat_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  input  logic [IW-1:0]                 in_item,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_channel,
  output logic                          out_last
);
  import awsat_pkg::*;

  localparam int   SB      = SAMPLE_BITS;
  localparam int   SFRAC   = SB - 1;
  localparam int   D_SHIFT = SFRAC - COEF_FRAC_BITS;
  localparam ext_t ONE_S   = ext_t'(1) <<< SFRAC;
  localparam ext_t K06     = (6 * ONE_S + 5) / 10;
  localparam ext_t K075    = (3 * ONE_S) / 4;
  localparam ext_t OUT_MAX = ONE_S - 1;
  localparam ext_t OUT_MIN = -ONE_S;
  localparam int   MIX_W   = 36;

  typedef struct packed {
    logic signed [SB-1:0] x;
    wide_t                s;
    wide_t                mb;
    wide_t                mq;
    wide_t                cst;
    curve_t               curve;
    logic                 act;
    logic                 neg;
    logic                 qneg;
    logic                 dzero;
    logic                 nzero;
    logic                 nneg;
    logic                 ch;
    logic                 last;
  } side_t;

  localparam int SW = $bits(side_t);

  // coefficient into the sample domain
  function automatic wide_t c2s(coef_t c);
    ext_t  e;
    wide_t r;
    e = ext_t'(c);
    if (D_SHIFT >= 0) r = sat_w(e <<< (D_SHIFT >= 0 ? D_SHIFT : 0));
    else r = sat_w(rshr(e, int'(D_SHIFT < 0 ? -D_SHIFT : 1)));
    return r;
  endfunction

  function automatic wide_t mulc(ext_t p);
    return sat_w(rshr(p, COEF_FRAC_BITS));
  endfunction

  // queue entry fields
  logic signed [SB-1:0] x_c;
  wide_t                s_c;
  logic signed [CW:0]   cax_c;
  logic                 ch_c, last_c;

  assign last_c = in_item[0];
  assign ch_c   = in_item[1];
  assign cax_c  = in_item[CW+2:2];
  assign s_c    = in_item[WW+CW+2:CW+3];
  assign x_c    = in_item[IW-1:WW+CW+3];

  // ---------------- stage 1: curve selection and first products
  logic signed [SB:0]      ax_c;
  wide_t                   p2_c, p4_c, kp_c, cst1_c;
  coef_t                   kc_c, mbc_c, pa_a, mcoef;
  wide_t                   pa_b;
  logic signed [CW:0]      ma_c;
  logic signed [CW+CW:0]   prod_m;
  logic signed [2*CW-1:0]  prod_p;
  logic                    hi_c, lo_c, act1_c, neg1_c;
  logic signed [CW+1:0]    den1_c;

  always_comb begin
    ax_c   = (x_c < 0) ? -((SB+1)'(x_c)) : (SB+1)'(x_c);
    p2_c   = c2s(cfg.c2);
    p4_c   = c2s(cfg.c4);
    hi_c   = (s_c > p2_c);
    lo_c   = !hi_c && (s_c < p4_c);
    kc_c   = hi_c ? cfg.c1 : cfg.c3;
    kp_c   = hi_c ? p2_c : p4_c;
    mcoef  = cfg.c1;
    ma_c   = (CW+1)'(x_c);
    mbc_c  = kc_c;
    pa_a   = kc_c;
    pa_b   = kp_c;
    cst1_c = kp_c;
    act1_c = hi_c || lo_c;
    neg1_c = 1'b0;
    case (cfg.curve)
      CURVE_KNEE: begin
        act1_c = hi_c || lo_c;
      end
      CURVE_RATIONAL: begin
        ma_c   = (CW+1)'(ax_c);
        mbc_c  = cfg.c2;
        cst1_c = '0;
        act1_c = 1'b1;
      end
      CURVE_QUAD: begin
        ma_c   = (CW+1)'(s_c);
        mbc_c  = cfg.c2;
        pa_a   = s_c;
        pa_b   = s_c;
        cst1_c = c2s(cfg.c3);
        act1_c = (ext_t'(s_c) < -K06) || (ext_t'(s_c) > K06);
        neg1_c = (ext_t'(s_c) < -K06);
      end
      CURVE_LINEAR: begin
        ma_c   = (CW+1)'(s_c);
        mbc_c  = mcoef;
        cst1_c = c2s(cfg.c2);
        act1_c = (ext_t'(s_c) < -K075) || (ext_t'(s_c) > K075);
        neg1_c = (ext_t'(s_c) < -K075);
      end
      default: begin
        act1_c = hi_c || lo_c;
      end
    endcase
    prod_m = ma_c * mbc_c;
    prod_p = pa_a * pa_b;
    den1_c = (cfg.curve == CURVE_KNEE) ? (CW+2)'(cfg.c0)
                                       : (CW+2)'(cfg.c1) + (CW+2)'(cax_c);
  end

  logic                   b1_v_r;
  logic signed [SB-1:0]   b1_x_r;
  wide_t                  b1_s_r, b1_mb_r, b1_cst_r;
  logic signed [2*CW-1:0] b1_pa_r;
  logic signed [CW+1:0]   b1_den_r;
  curve_t                 b1_curve_r;
  logic                   b1_act_r, b1_neg_r, b1_ch_r, b1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else begin
      b1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    b1_x_r     <= x_c;
    b1_s_r     <= s_c;
    b1_mb_r    <= mulc(ext_t'(prod_m));
    b1_cst_r   <= cst1_c;
    b1_pa_r    <= prod_p;
    b1_den_r   <= den1_c;
    b1_curve_r <= cfg.curve;
    b1_act_r   <= act1_c;
    b1_neg_r   <= neg1_c;
    b1_ch_r    <= ch_c;
    b1_last_r  <= last_c;
  end

  // ---------------- stage 2: dividend, divisor magnitudes and the square
  logic signed [2*CW-1:0] num_c, num_abs;
  logic signed [CW+1:0]   den_abs;
  wide_t                  sq_c;

  always_comb begin
    num_c   = (b1_curve_r == CURVE_KNEE) ? b1_pa_r
                                         : ((2*CW)'(b1_x_r) <<< COEF_FRAC_BITS);
    num_abs = (num_c < 0) ? -num_c : num_c;
    den_abs = (b1_den_r < 0) ? -b1_den_r : b1_den_r;
    sq_c    = sat_w(rshr(ext_t'(b1_pa_r), SFRAC));
  end

  logic              b2_v_r;
  logic [DIV_NW-1:0] b2_mag_r;
  logic [DIV_DW-1:0] b2_dmag_r;
  wide_t             b2_sq_r;
  side_t             b2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b2_mag_r        <= num_abs[DIV_NW-1:0];
    b2_dmag_r       <= den_abs[DIV_DW-1:0];
    b2_sq_r         <= sq_c;
    b2_side_r.x     <= b1_x_r;
    b2_side_r.s     <= b1_s_r;
    b2_side_r.mb    <= b1_mb_r;
    b2_side_r.mq    <= '0;
    b2_side_r.cst   <= b1_cst_r;
    b2_side_r.curve <= b1_curve_r;
    b2_side_r.act   <= b1_act_r;
    b2_side_r.neg   <= b1_neg_r;
    b2_side_r.qneg  <= (num_c < 0) ^ (b1_den_r < 0);
    b2_side_r.dzero <= (b1_den_r == '0);
    b2_side_r.nzero <= (num_c == '0);
    b2_side_r.nneg  <= (num_c < 0);
    b2_side_r.ch    <= b1_ch_r;
    b2_side_r.last  <= b1_last_r;
  end

  // ---------------- stage 3: quadratic term
  logic signed [CW:0]    c1s_c;
  logic signed [2*CW:0]  prod_q;
  side_t                 b3_side_nxt;

  always_comb begin
    c1s_c          = b2_side_r.neg ? (CW+1)'(cfg.c1) : -((CW+1)'(cfg.c1));
    prod_q         = b2_sq_r * c1s_c;
    b3_side_nxt    = b2_side_r;
    b3_side_nxt.mq = mulc(ext_t'(prod_q));
  end

  logic              b3_v_r;
  logic [DIV_NW-1:0] b3_mag_r;
  logic [DIV_DW-1:0] b3_dmag_r;
  side_t             b3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b3_mag_r  <= b2_mag_r;
    b3_dmag_r <= b2_dmag_r;
    b3_side_r <= b3_side_nxt;
  end

  // ---------------- quotient
  logic              dv_v;
  logic [DIV_NW-1:0] dv_q;
  logic [SW-1:0]     dv_side_bits;
  side_t             dv_side;

  awsat_div #(
    .NW (DIV_NW),
    .DW (DIV_DW),
    .SW (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b3_v_r),
    .in_num    (b3_mag_r),
    .in_den    (b3_dmag_r),
    .in_side   (b3_side_r),
    .out_valid (dv_v),
    .out_quot  (dv_q),
    .out_side  (dv_side_bits)
  );

  assign dv_side = side_t'(dv_side_bits);

  // ---------------- stage 4: curve output
  ext_t  qe, tv;
  wide_t t_c, y_c;

  always_comb begin
    qe = ext_t'({1'b0, dv_q});
    tv = dv_side.qneg ? -qe : qe;
    if (dv_side.dzero) begin
      if (dv_side.nzero) t_c = '0;
      else t_c = dv_side.nneg ? wide_t'(WIDE_MIN) : wide_t'(WIDE_MAX);
    end else begin
      t_c = sat_w(tv);
    end
    case (dv_side.curve)
      CURVE_KNEE: begin
        y_c = dv_side.act
            ? sat_w(ext_t'(dv_side.mb) + ext_t'(sat_w(ext_t'(dv_side.cst) - ext_t'(t_c))))
            : dv_side.s;
      end
      CURVE_RATIONAL: begin
        y_c = sat_w(ext_t'(t_c) + ext_t'(dv_side.mb));
      end
      CURVE_QUAD: begin
        if (!dv_side.act) y_c = dv_side.s;
        else if (dv_side.neg)
          y_c = sat_w(ext_t'(dv_side.mq) + ext_t'(dv_side.mb) + ext_t'(dv_side.cst));
        else
          y_c = sat_w(ext_t'(dv_side.mq) + ext_t'(dv_side.mb) - ext_t'(dv_side.cst));
      end
      CURVE_LINEAR: begin
        if (!dv_side.act) y_c = dv_side.s;
        else if (dv_side.neg) y_c = sat_w(ext_t'(dv_side.mb) + ext_t'(dv_side.cst));
        else y_c = sat_w(ext_t'(dv_side.mb) - ext_t'(dv_side.cst));
      end
      default: begin
        y_c = dv_side.s;
      end
    endcase
  end

  logic                 b4_v_r;
  wide_t                b4_y_r;
  logic signed [SB-1:0] b4_x_r;
  logic                 b4_ch_r, b4_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b4_v_r <= 1'b0;
    end else begin
      b4_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    b4_y_r    <= y_c;
    b4_x_r    <= dv_side.x;
    b4_ch_r   <= dv_side.ch;
    b4_last_r <= dv_side.last;
  end

  // ---------------- stage 5: wet/dry mix
  logic [FR_W-1:0]             wet_c, dry_c, vol_c;
  logic signed [FR_W+WW:0]     pw_c;
  logic signed [FR_W+SB:0]     pd_c;
  ext_t                        mix_e;

  always_comb begin
    wet_c = (cfg.wet > FR_W'(UNITY)) ? FR_W'(UNITY) : cfg.wet;
    dry_c = FR_W'(UNITY) - wet_c;
    vol_c = (cfg.vol > FR_W'(UNITY)) ? FR_W'(UNITY) : cfg.vol;
    pw_c  = $signed({1'b0, wet_c}) * b4_y_r;
    pd_c  = $signed({1'b0, dry_c}) * b4_x_r;
    mix_e = rshr(ext_t'(pw_c) + ext_t'(pd_c), 16);
  end

  logic                    b5_v_r;
  logic signed [MIX_W-1:0] b5_mix_r;
  logic                    b5_ch_r, b5_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b5_v_r <= 1'b0;
    end else begin
      b5_v_r <= b4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b5_mix_r  <= mix_e[MIX_W-1:0];
    b5_ch_r   <= b4_ch_r;
    b5_last_r <= b4_last_r;
  end

  // ---------------- stage 6: master gain and output clip
  logic signed [MIX_W+FR_W:0] pv_c;
  ext_t                       g_e;
  logic signed [SB-1:0]       o_c;

  always_comb begin
    pv_c = b5_mix_r * $signed({1'b0, vol_c});
    g_e  = rshr(ext_t'(pv_c), 16);
    if (g_e > OUT_MAX) o_c = SB'(OUT_MAX);
    else if (g_e < OUT_MIN) o_c = SB'(OUT_MIN);
    else o_c = SB'(g_e);
  end

  logic                 b6_v_r;
  logic signed [SB-1:0] b6_y_r;
  logic                 b6_ch_r, b6_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b6_v_r <= 1'b0;
    end else begin
      b6_v_r <= b5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b6_y_r    <= o_c;
    b6_ch_r   <= b5_ch_r;
    b6_last_r <= b5_last_r;
  end

  assign out_valid   = b6_v_r;
  assign out_sample  = b6_y_r;
  assign out_channel = b6_ch_r;
  assign out_last    = b6_last_r;

endmodule

// ----- hdl/audio_waveshaping_saturator_top.sv -----
// ----------------------------------------------------------------------------
// audio_waveshaping_saturator_top
// Saturating waveshaper with wet/dry mix and master gain for audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_sample_in, in_channel_in and in_end_of_block with start
//   high; the transaction is taken at a rising edge where busy is low.
//   Output: each result shows on the out_ ports for one cycle with out_valid
//   high; the receiver has no way to hold it, so it must sample it then.
//   Configuration: cfg_valid with cfg_index and cfg_data writes one register;
//   cfg_ready is always high. Write only while no sample is in flight.
//   Path: a sample passes the front register, the queue, back stages 1 to 3,
//   the 63-stage divider pipeline and back stages 4 to 6 to the out_ ports.
//   Throughput: one sample per clock; busy only rises if the queue between
//   the front and back parts nearly fills, which does not happen as the
//   back part drains one entry each cycle.
//   Reset: rst_n low for one edge clears all pipeline valids and the queue
//   and loads register defaults (knee curve, unit drive, full wet, unit gain).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_waveshaping_saturator_top #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  input  logic                                 in_channel_in,
  input  logic                                 in_end_of_block,
  output logic                                 out_valid,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic                                 out_channel_out,
  output logic                                 out_block_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [awsat_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [awsat_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import awsat_pkg::*;

  localparam int IW = SAMPLE_BITS + WW + CW + 1 + 2;

  cfg_t cfg_r, cfg_nxt;
  logic cfg_we;

  // register writes
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CURVE:  cfg_nxt.curve = curve_t'(cfg_data[1:0]);
        REG_COEF0:  cfg_nxt.c0    = coef_t'(cfg_data);
        REG_COEF1:  cfg_nxt.c1    = coef_t'(cfg_data);
        REG_COEF2:  cfg_nxt.c2    = coef_t'(cfg_data);
        REG_COEF3:  cfg_nxt.c3    = coef_t'(cfg_data);
        REG_COEF4:  cfg_nxt.c4    = coef_t'(cfg_data);
        REG_WET:    cfg_nxt.wet   = cfg_data[FR_W-1:0];
        REG_VOLUME: cfg_nxt.vol   = cfg_data[FR_W-1:0];
        default:    cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve <= CURVE_KNEE;
      cfg_r.c0    <= coef_t'(1) <<< COEF_FRAC_BITS;
      cfg_r.c1    <= '0;
      cfg_r.c2    <= '0;
      cfg_r.c3    <= '0;
      cfg_r.c4    <= '0;
      cfg_r.wet   <= FR_W'(UNITY);
      cfg_r.vol   <= FR_W'(UNITY);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front, queue and back parts
  logic          push;
  logic [IW-1:0] f_item, q_item;
  q_status_t     qs;

  awsat_front #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .IW             (IW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .sample  (in_sample_in),
    .channel (in_channel_in),
    .last    (in_end_of_block),
    .cfg     (cfg_r),
    .qs      (qs),
    .push    (push),
    .item    (f_item)
  );

  awsat_queue #(
    .WIDTH (IW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (f_item),
    .rdata  (q_item),
    .status (qs)
  );

  awsat_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .IW             (IW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (qs.not_empty),
    .in_item     (q_item),
    .out_valid   (out_valid),
    .out_sample  (out_sample_out),
    .out_channel (out_channel_out),
    .out_last    (out_block_last)
  );

endmodule
